// File: hw/rtl/sorted_priority_queue_core_assert.svh
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked and disabled under reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define SPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue: next-cycle check failed");

// Condition holds at every clock edge out of reset.
`define SPQ_ASSERT_ALW(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sorted priority queue: invariant failed");

`endif

// File: hw/rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, request and result types, operation codes and cell control types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned KEY_BITS = 16;
	localparam int unsigned TAG_BITS = 16;
	localparam int unsigned IDX_BITS = $clog2(DEPTH);
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_PEEK   = 3'd1;
	localparam logic [2:0] KIND_POLL   = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_REMOVE = 3'd4;
	localparam logic [2:0] KIND_PURGE  = 3'd5;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_NONE = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]          kind;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic [IDX_BITS-1:0] index;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [KEY_BITS-1:0] entry_key;
		logic [TAG_BITS-1:0] entry_tag;
		logic [IDX_BITS-1:0] position;
		logic [CNT_BITS-1:0] removed_count;
		logic [CNT_BITS-1:0] size_now;
	} spq_res_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DROP,
		CELL_PURGE
	} spq_cell_op_t;

	typedef struct packed {
		spq_cell_op_t        op;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic [IDX_BITS-1:0] drop_idx;
		logic [CNT_BITS-1:0] count;
	} spq_cell_ctrl_t;

	typedef struct packed {
		logic gt;
		logic hit;
	} spq_link_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_PURGE
	} spq_state_t;

endpackage

// File: hw/rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and moves it toward or away from the head as told.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
#(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                clk,
	input  spq_cell_ctrl_t      ctrl,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [TAG_BITS-1:0] left_tag,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [TAG_BITS-1:0] right_tag,
	input  spq_link_t           link_in,
	output spq_link_t           link_out,
	output logic [KEY_BITS-1:0] key,
	output logic [TAG_BITS-1:0] tag
);

	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [KEY_BITS-1:0] key_nx;
	logic [TAG_BITS-1:0] tag_nx;
	logic                occupied;
	logic                gt;
	logic                hit;

	always_comb begin
		occupied = CNT_BITS'(CELL_IDX) < ctrl.count;
		gt       = occupied && (ctrl.key > key_q);
		case (ctrl.op)
			CELL_PURGE: hit = link_in.hit | (occupied && (tag_q == ctrl.tag));
			CELL_DROP:  hit = link_in.hit | (ctrl.drop_idx == IDX_BITS'(CELL_IDX));
			default:    hit = 1'b0;
		endcase
		link_out.gt  = gt;
		link_out.hit = hit;
	end

	always_comb begin
		key_nx = key_q;
		tag_nx = tag_q;
		case (ctrl.op)
			CELL_INSERT: begin
				if (!gt && link_in.gt) begin
					key_nx = ctrl.key;
					tag_nx = ctrl.tag;
				end else if (!gt) begin
					key_nx = left_key;
					tag_nx = left_tag;
				end
			end
			CELL_DROP, CELL_PURGE: begin
				if (hit) begin
					key_nx = right_key;
					tag_nx = right_tag;
				end
			end
			default: begin
				key_nx = key_q;
				tag_nx = tag_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_nx;
		tag_q <= tag_nx;
	end

	assign key = key_q;
	assign tag = tag_q;

endmodule

// File: hw/rtl/sorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// Sorted priority queue core
// A row of entry cells kept in ascending key order, with a small sequencer.
// ---------------------------------------------------------------------------
//  Channel   Handshake         Payload
//  request   start / busy      req    (kind, key, tag, index)
//  result    done (strobe)     result (status, entry_key, entry_tag, position,
//                                      removed_count, size_now)
//
// Insert, peek, poll, read and remove at index take the request while idle
// and then run in a single execute state in which every cell shifts at once.
// Remove by tag stays in the purge state while a matching entry is found,
// since the cell row closes one gap per cycle.
// Reset clears the state, the fill count and the strobe; entry storage is not
// cleared. The result strobe lasts one cycle and cannot be held off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  spq_req_t req,
	output logic     busy,
	output logic     done,
	output spq_res_t result
);

	spq_state_t          state_q;
	spq_state_t          state_nx;
	spq_req_t            cmd_q;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] count_nx;
	logic [CNT_BITS-1:0] removed_q;
	logic [CNT_BITS-1:0] removed_nx;
	spq_res_t            res_q;
	spq_res_t            res_nx;
	logic                done_q;
	logic                done_nx;
	spq_cell_ctrl_t      ctrl;
	logic [IDX_BITS-1:0] ins_pos;
	logic                accept;

	logic [KEY_BITS-1:0] cell_key [DEPTH];
	logic [TAG_BITS-1:0] cell_tag [DEPTH];
	spq_link_t           links    [DEPTH+1];

	assign links[0] = '{gt: 1'b1, hit: 1'b0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] lkey;
		logic [TAG_BITS-1:0] ltag;
		logic [KEY_BITS-1:0] rkey;
		logic [TAG_BITS-1:0] rtag;

		if (i == 0) begin : g_first
			assign lkey = '0;
			assign ltag = '0;
		end else begin : g_mid
			assign lkey = cell_key[i-1];
			assign ltag = cell_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rkey = '0;
			assign rtag = '0;
		end else begin : g_inner
			assign rkey = cell_key[i+1];
			assign rtag = cell_tag[i+1];
		end

		spq_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.left_key (lkey),
			.left_tag (ltag),
			.right_key(rkey),
			.right_tag(rtag),
			.link_in  (links[i]),
			.link_out (links[i+1]),
			.key      (cell_key[i]),
			.tag      (cell_tag[i])
		);
	end

	assign accept = start && (state_q == FSM_IDLE);

	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (links[i].gt && !links[i+1].gt) begin
				ins_pos = ins_pos | IDX_BITS'(i);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (start && (req.kind == KIND_PURGE)) begin
					state_nx = FSM_PURGE;
				end else if (start) begin
					state_nx = FSM_EXEC;
				end
			end
			FSM_EXEC: state_nx = FSM_IDLE;
			FSM_PURGE: begin
				if (!links[DEPTH].hit) begin
					state_nx = FSM_IDLE;
				end
			end
			default: state_nx = FSM_IDLE;
		endcase
	end

	always_comb begin
		busy          = state_q != FSM_IDLE;
		ctrl.op       = CELL_HOLD;
		ctrl.key      = cmd_q.key;
		ctrl.tag      = cmd_q.tag;
		ctrl.drop_idx = cmd_q.index;
		ctrl.count    = count_q;
		res_nx        = '0;
		done_nx       = 1'b0;
		count_nx      = count_q;
		removed_nx    = removed_q;
		case (state_q)
			FSM_IDLE: removed_nx = '0;
			FSM_EXEC: begin
				done_nx = 1'b1;
				case (cmd_q.kind)
					KIND_INSERT: begin
						if (count_q == CNT_BITS'(DEPTH)) begin
							res_nx.status = STATUS_FULL;
						end else begin
							ctrl.op         = CELL_INSERT;
							res_nx.position = ins_pos;
							count_nx        = count_q + 1'b1;
						end
					end
					KIND_PEEK, KIND_POLL: begin
						if (count_q == '0) begin
							res_nx.status = STATUS_NONE;
						end else begin
							res_nx.entry_key = cell_key[0];
							res_nx.entry_tag = cell_tag[0];
							if (cmd_q.kind == KIND_POLL) begin
								ctrl.op       = CELL_DROP;
								ctrl.drop_idx = '0;
								count_nx      = count_q - 1'b1;
							end
						end
					end
					KIND_READ, KIND_REMOVE: begin
						if (CNT_BITS'(cmd_q.index) >= count_q) begin
							res_nx.status = STATUS_NONE;
						end else begin
							res_nx.entry_key = cell_key[cmd_q.index];
							res_nx.entry_tag = cell_tag[cmd_q.index];
							if (cmd_q.kind == KIND_REMOVE) begin
								ctrl.op  = CELL_DROP;
								count_nx = count_q - 1'b1;
							end
						end
					end
					default: res_nx.status = STATUS_NONE;
				endcase
				res_nx.size_now = count_nx;
			end
			FSM_PURGE: begin
				ctrl.op = CELL_PURGE;
				if (links[DEPTH].hit) begin
					count_nx   = count_q - 1'b1;
					removed_nx = removed_q + 1'b1;
				end else begin
					done_nx              = 1'b1;
					res_nx.removed_count = removed_q;
					res_nx.size_now      = count_q;
				end
			end
			default: ctrl.op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_nx;
			count_q   <= count_nx;
			removed_q <= removed_nx;
			done_q    <= done_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		res_q <= res_nx;
	end

	assign done   = done_q;
	assign result = res_q;

	`SPQ_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == FSM_IDLE)
	`SPQ_ASSERT_ALW(a_count_bound, clk, arst_n, count_q <= CNT_BITS'(DEPTH))
	`SPQ_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy)
	`SPQ_ASSERT_IMP(a_full_size, clk, arst_n, done_q && (res_q.status == STATUS_FULL), res_q.size_now == CNT_BITS'(DEPTH))

endmodule
